// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, sampled on i_clk, off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ppr_pkg.sv =====
`timescale 1ns / 1ps

package ppr_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int ID_W         = 16;
    localparam int HALF_W       = 16;
    localparam int PRIO_W       = 8;
    localparam int TIME_W       = 32;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [HALF_W-1:0] TQ_RESET = 16'd1;
    localparam logic              REG_TQ   = 1'b0;

    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [PRIO_W-1:0] prio;
    } t_qctl;

    typedef struct packed {
        logic              occ;
        logic              keep;
        logic [PRIO_W-1:0] prio;
    } t_qtag;

endpackage

// ===== hw/rtl/ppr_cell.sv =====
`timescale 1ns / 1ps

module ppr_cell
    import ppr_pkg::*;
#(
    parameter int SLOT_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qctl             i_ctl,
    input  logic [SLOT_W-1:0] i_new_slot,
    input  t_qtag             i_left,
    input  logic [SLOT_W-1:0] i_left_slot,
    input  t_qtag             i_right,
    input  logic [SLOT_W-1:0] i_right_slot,
    output t_qtag             o_tag,
    output logic [SLOT_W-1:0] o_slot
);

    logic              r_occ;
    logic [SLOT_W-1:0] r_slot;
    logic [PRIO_W-1:0] r_prio;
    logic              w_keep;

    // entry stays put on insert when it is not less urgent than the newcomer
    assign w_keep   = r_occ && (r_prio <= i_ctl.prio);
    assign o_tag    = '{occ: r_occ, keep: w_keep, prio: r_prio};
    assign o_slot   = r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.ins) begin
            if (!w_keep) begin
                r_occ <= r_occ | i_left.occ;
            end
        end else if (i_ctl.pop) begin
            r_occ <= i_right.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (!w_keep) begin
                if (i_left.keep) begin
                    r_slot <= i_new_slot;
                    r_prio <= i_ctl.prio;
                end else begin
                    r_slot <= i_left_slot;
                    r_prio <= i_left.prio;
                end
            end
        end else if (i_ctl.pop) begin
            r_slot <= i_right_slot;
            r_prio <= i_right.prio;
        end
    end

endmodule

// ===== hw/rtl/ppr_queue.sv =====
`timescale 1ns / 1ps

module ppr_queue
    import ppr_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF,
    parameter int SLOT_W   = $clog2(MAX_JOBS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qctl             i_ctl,
    input  logic [SLOT_W-1:0] i_new_slot,
    output t_qtag             o_head,
    output logic [SLOT_W-1:0] o_head_slot
);

    localparam t_qtag TAG_FRONT = '{occ: 1'b1, keep: 1'b1, prio: '0};
    localparam t_qtag TAG_EMPTY = '{occ: 1'b0, keep: 1'b0, prio: '0};

    t_qtag             w_tag        [MAX_JOBS];
    logic [SLOT_W-1:0] w_slot       [MAX_JOBS];
    t_qtag             w_left       [MAX_JOBS];
    logic [SLOT_W-1:0] w_left_slot  [MAX_JOBS];
    t_qtag             w_right      [MAX_JOBS];
    logic [SLOT_W-1:0] w_right_slot [MAX_JOBS];

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        if (g == 0) begin : g_front
            assign w_left[g]      = TAG_FRONT;
            assign w_left_slot[g] = '0;
        end else begin : g_mid_l
            assign w_left[g]      = w_tag[g-1];
            assign w_left_slot[g] = w_slot[g-1];
        end
        if (g == MAX_JOBS - 1) begin : g_back
            assign w_right[g]      = TAG_EMPTY;
            assign w_right_slot[g] = '0;
        end else begin : g_mid_r
            assign w_right[g]      = w_tag[g+1];
            assign w_right_slot[g] = w_slot[g+1];
        end

        ppr_cell #(
            .SLOT_W(SLOT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_new_slot  (i_new_slot),
            .i_left      (w_left[g]),
            .i_left_slot (w_left_slot[g]),
            .i_right     (w_right[g]),
            .i_right_slot(w_right_slot[g]),
            .o_tag       (w_tag[g]),
            .o_slot      (w_slot[g])
        );
    end

    assign o_head      = w_tag[0];
    assign o_head_slot = w_slot[0];

endmodule

// ===== hw/rtl/ppr_job_mem.sv =====
`timescale 1ns / 1ps

module ppr_job_mem
    import ppr_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF,
    parameter int SLOT_W   = $clog2(MAX_JOBS)
) (
    input  logic              i_clk,
    input  logic              i_we_all,
    input  logic              i_we_rem,
    input  logic [SLOT_W-1:0] i_waddr,
    input  logic [ID_W-1:0]   i_wid,
    input  logic [HALF_W-1:0] i_warr,
    input  logic [HALF_W-1:0] i_wburst,
    input  logic [PRIO_W-1:0] i_wprio,
    input  logic [HALF_W-1:0] i_wrem,
    input  logic [SLOT_W-1:0] i_raddr,
    output logic [ID_W-1:0]   o_rid,
    output logic [HALF_W-1:0] o_rarr,
    output logic [HALF_W-1:0] o_rburst,
    output logic [PRIO_W-1:0] o_rprio,
    output logic [HALF_W-1:0] o_rrem
);

    logic [ID_W-1:0]   mem_id    [MAX_JOBS];
    logic [HALF_W-1:0] mem_arr   [MAX_JOBS];
    logic [HALF_W-1:0] mem_burst [MAX_JOBS];
    logic [PRIO_W-1:0] mem_prio  [MAX_JOBS];
    logic [HALF_W-1:0] mem_rem   [MAX_JOBS];

    always_ff @(posedge i_clk) begin
        if (i_we_all) begin
            mem_id[i_waddr]    <= i_wid;
            mem_arr[i_waddr]   <= i_warr;
            mem_burst[i_waddr] <= i_wburst;
            mem_prio[i_waddr]  <= i_wprio;
        end
        if (i_we_all || i_we_rem) begin
            mem_rem[i_waddr] <= i_wrem;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rid    <= mem_id[i_raddr];
        o_rarr   <= mem_arr[i_raddr];
        o_rburst <= mem_burst[i_raddr];
        o_rprio  <= mem_prio[i_raddr];
        o_rrem   <= mem_rem[i_raddr];
    end

endmodule

// ===== hw/rtl/preemptive_priority_rr_scheduler_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_op i_job_id i_arrival i_burst i_prio
// result    out        o_valid / i_ready   o_ran_* o_finished o_*time o_turnaround ...
// config    in         APB psel/penable    paddr pwdata prdata, pready tied high
//
// Admit: IDLE then FIN. Tick: SCAN, START, LOAD (only when a job starts), EXEC, CALC, FIN;
// the arrival scan reads the job table through its single read port, one entry per cycle.
// One request in flight; the next is taken once the result sits in the output
// register, which holds until i_ready. Synchronous active-low reset, no clearing pass.

module preemptive_priority_rr_scheduler_top
    import ppr_pkg::*;
#(
    parameter int MAX_JOBS = MAX_JOBS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [ID_W-1:0]   i_job_id,
    input  logic [HALF_W-1:0] i_arrival,
    input  logic [HALF_W-1:0] i_burst,
    input  logic [PRIO_W-1:0] i_prio,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_ran_valid,
    output logic [ID_W-1:0]   o_ran_id,
    output logic              o_finished,
    output logic [TIME_W-1:0] o_completion_time,
    output logic [TIME_W-1:0] o_turnaround,
    output logic [TIME_W-1:0] o_waiting,
    output logic              o_all_done,
    output logic              o_table_full,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SLOT_W = $clog2(MAX_JOBS);
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;
    localparam logic [2:0] ST_CALC  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    localparam logic OP_ADMIT = 1'b0;

    logic [2:0]          r_state;
    logic [HALF_W-1:0]   r_tq;
    logic [CNT_W-1:0]    r_loaded;
    logic [CNT_W-1:0]    r_exited;
    logic [TIME_W-1:0]   r_now;
    logic [CNT_W-1:0]    r_idx;
    logic                r_chk_vld;
    logic [SLOT_W-1:0]   r_chk_slot;
    logic [MAX_JOBS-1:0] r_new;
    logic                r_run_vld;
    logic [SLOT_W-1:0]   r_run_slot;
    logic [ID_W-1:0]     r_run_id;
    logic [HALF_W-1:0]   r_run_arr;
    logic [HALF_W-1:0]   r_run_burst;
    logic [HALF_W-1:0]   r_run_rem;
    logic [PRIO_W-1:0]   r_run_prio;
    logic [HALF_W-1:0]   r_slice;

    logic                r_res_ran;
    logic [ID_W-1:0]     r_res_id;
    logic                r_res_fin;
    logic [TIME_W-1:0]   r_res_ct;
    logic [TIME_W-1:0]   r_res_tat;
    logic [TIME_W-1:0]   r_res_wt;
    logic                r_res_full;

    logic                r_out_valid;
    logic                r_out_ran;
    logic [ID_W-1:0]     r_out_id;
    logic                r_out_fin;
    logic [TIME_W-1:0]   r_out_ct;
    logic [TIME_W-1:0]   r_out_tat;
    logic [TIME_W-1:0]   r_out_wt;
    logic                r_out_done;
    logic                r_out_full;

    logic                w_in_acc;
    logic                w_admit;
    logic                w_full;
    logic                w_cfg_wr;
    logic                w_idx_ok;
    logic                w_hit;
    logic                w_pop;
    logic                w_done;
    logic                w_requeue;
    logic                w_out_free;
    logic [HALF_W-1:0]   w_rem_dec;
    logic [HALF_W-1:0]   w_slice_inc;
    logic [HALF_W-1:0]   w_q;
    logic [TIME_W-1:0]   w_tat;
    logic [TIME_W-1:0]   w_arr_ext;
    logic [TIME_W-1:0]   w_burst_ext;
    t_qctl               w_qctl;
    logic [SLOT_W-1:0]   w_qslot;
    t_qtag               w_head;
    logic [SLOT_W-1:0]   w_head_slot;
    logic                w_we_all;
    logic                w_we_rem;
    logic [SLOT_W-1:0]   w_waddr;
    logic [HALF_W-1:0]   w_wrem;
    logic [SLOT_W-1:0]   w_raddr;
    logic [ID_W-1:0]     w_rid;
    logic [HALF_W-1:0]   w_rarr;
    logic [HALF_W-1:0]   w_rburst;
    logic [PRIO_W-1:0]   w_rprio;
    logic [HALF_W-1:0]   w_rrem;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_TQ) ? {{(APB_DW-HALF_W){1'b0}}, r_tq} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tq <= TQ_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_TQ)) begin
            r_tq <= pwdata[HALF_W-1:0];
        end
    end

    // handshake
    assign o_ready    = (r_state == ST_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_full     = (r_loaded >= CNT_MAX);
    assign w_admit    = w_in_acc && (i_op == OP_ADMIT) && !w_full;
    assign w_out_free = !r_out_valid || i_ready;

    // arrival scan
    assign w_idx_ok  = (r_idx < r_loaded);
    assign w_arr_ext = {{(TIME_W-HALF_W){1'b0}}, w_rarr};
    assign w_hit     = (r_state == ST_SCAN) && r_chk_vld && r_new[r_chk_slot] &&
                       (r_now >= w_arr_ext);

    // running job
    assign w_pop       = (r_state == ST_START) && !r_run_vld && w_head.occ;
    assign w_rem_dec   = (r_run_rem != '0) ? r_run_rem - 1'b1 : '0;
    assign w_slice_inc = (r_slice != '1) ? r_slice + 1'b1 : r_slice;
    assign w_q         = (r_tq == '0) ? HALF_W'(1) : r_tq;
    assign w_done      = (w_rem_dec == '0);
    assign w_requeue   = (r_state == ST_EXEC) && r_run_vld && !w_done &&
                         ((w_slice_inc >= w_q) ||
                          (w_head.occ && (r_run_prio > w_head.prio)));
    assign w_tat       = (r_now >= {{(TIME_W-HALF_W){1'b0}}, r_run_arr}) ?
                         r_now - {{(TIME_W-HALF_W){1'b0}}, r_run_arr} : '0;
    assign w_burst_ext = {{(TIME_W-HALF_W){1'b0}}, r_run_burst};

    // ready queue control
    always_comb begin
        w_qctl.ins  = w_hit || w_requeue;
        w_qctl.pop  = w_pop;
        w_qctl.prio = (r_state == ST_SCAN) ? w_rprio : r_run_prio;
        w_qslot     = (r_state == ST_SCAN) ? r_chk_slot : r_run_slot;
    end

    // job table ports
    assign w_we_all = w_admit;
    assign w_we_rem = w_requeue;
    assign w_waddr  = w_admit ? r_loaded[SLOT_W-1:0] : r_run_slot;
    assign w_wrem   = w_admit ? i_burst : w_rem_dec;
    assign w_raddr  = (r_state == ST_SCAN) ? r_idx[SLOT_W-1:0] : w_head_slot;

    ppr_queue #(
        .MAX_JOBS(MAX_JOBS),
        .SLOT_W  (SLOT_W)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_qctl),
        .i_new_slot (w_qslot),
        .o_head     (w_head),
        .o_head_slot(w_head_slot)
    );

    ppr_job_mem #(
        .MAX_JOBS(MAX_JOBS),
        .SLOT_W  (SLOT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we_all(w_we_all),
        .i_we_rem(w_we_rem),
        .i_waddr (w_waddr),
        .i_wid   (i_job_id),
        .i_warr  (i_arrival),
        .i_wburst(i_burst),
        .i_wprio (i_prio),
        .i_wrem  (w_wrem),
        .i_raddr (w_raddr),
        .o_rid   (w_rid),
        .o_rarr  (w_rarr),
        .o_rburst(w_rburst),
        .o_rprio (w_rprio),
        .o_rrem  (w_rrem)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_loaded  <= '0;
            r_exited  <= '0;
            r_now     <= '0;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_run_vld <= 1'b0;
            r_slice   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_idx     <= '0;
                        r_chk_vld <= 1'b0;
                        if (i_op == OP_ADMIT) begin
                            if (!w_full) begin
                                r_loaded <= r_loaded + 1'b1;
                            end
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_chk_vld <= w_idx_ok;
                    if (w_idx_ok) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (!w_idx_ok && !r_chk_vld) begin
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    if (r_now != '1) begin
                        r_now <= r_now + 1'b1;
                    end
                    if (w_pop) begin
                        r_run_vld <= 1'b1;
                        r_slice   <= '0;
                        r_state   <= ST_LOAD;
                    end else begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (r_run_vld) begin
                        r_slice <= w_slice_inc;
                        if (w_done) begin
                            r_exited  <= r_exited + 1'b1;
                            r_run_vld <= 1'b0;
                        end else if (w_requeue) begin
                            r_run_vld <= 1'b0;
                        end
                    end
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_admit) begin
            r_new[r_loaded[SLOT_W-1:0]] <= 1'b1;
        end
        if (w_hit) begin
            r_new[r_chk_slot] <= 1'b0;
        end
        if (r_state == ST_SCAN) begin
            r_chk_slot <= r_idx[SLOT_W-1:0];
        end
        if (w_pop) begin
            r_run_slot <= w_head_slot;
        end
        if (r_state == ST_LOAD) begin
            r_run_id    <= w_rid;
            r_run_arr   <= w_rarr;
            r_run_burst <= w_rburst;
            r_run_rem   <= w_rrem;
            r_run_prio  <= w_rprio;
        end
        if (w_in_acc) begin
            r_res_ran  <= 1'b0;
            r_res_id   <= '0;
            r_res_fin  <= 1'b0;
            r_res_ct   <= '0;
            r_res_tat  <= '0;
            r_res_wt   <= '0;
            r_res_full <= (i_op == OP_ADMIT) && w_full;
        end
        if ((r_state == ST_EXEC) && r_run_vld) begin
            r_run_rem <= w_rem_dec;
            r_res_ran <= 1'b1;
            r_res_id  <= r_run_id;
            if (w_done) begin
                r_res_fin <= 1'b1;
                r_res_ct  <= r_now;
                r_res_tat <= w_tat;
            end
        end
        if ((r_state == ST_CALC) && r_res_fin) begin
            r_res_wt <= (r_res_tat >= w_burst_ext) ? r_res_tat - w_burst_ext : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && w_out_free) begin
            r_out_ran  <= r_res_ran;
            r_out_id   <= r_res_id;
            r_out_fin  <= r_res_fin;
            r_out_ct   <= r_res_ct;
            r_out_tat  <= r_res_tat;
            r_out_wt   <= r_res_wt;
            r_out_done <= (r_exited == r_loaded);
            r_out_full <= r_res_full;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_ran_valid       = r_out_ran;
    assign o_ran_id          = r_out_id;
    assign o_finished        = r_out_fin;
    assign o_completion_time = r_out_ct;
    assign o_turnaround      = r_out_tat;
    assign o_waiting         = r_out_wt;
    assign o_all_done        = r_out_done;
    assign o_table_full      = r_out_full;

endmodule

// ===== hw/rtl/ppr_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppr_checker
    import ppr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_ran_valid,
    input logic [ID_W-1:0]   o_ran_id,
    input logic              o_finished,
    input logic [TIME_W-1:0] o_completion_time,
    input logic [TIME_W-1:0] o_turnaround,
    input logic [TIME_W-1:0] o_waiting,
    input logic              o_table_full
);

    `PPR_ASSERT_NOW(a_fin_ran, o_valid && o_finished, o_ran_valid, "finished without a run")

    `PPR_ASSERT_NOW(a_full_quiet, o_valid && o_table_full, !o_ran_valid && !o_finished, "rejected admit shows a run")

    `PPR_ASSERT_NOW(a_times_zero, o_valid && !o_finished, (o_completion_time == 0) && (o_turnaround == 0) && (o_waiting == 0), "times set without completion")

    `PPR_ASSERT_NOW(a_times_order, o_valid && o_finished, (o_turnaround <= o_completion_time) && (o_waiting <= o_turnaround), "times out of order")

    `PPR_ASSERT_NEXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_ran_id) && $stable(o_completion_time), "stalled result changed")

endmodule

bind preemptive_priority_rr_scheduler_top ppr_checker u_ppr_checker (.*);

// ===== tb/preemptive_priority_rr_scheduler_top_tb.sv =====
`timescale 1ns / 1ps

module preemptive_priority_rr_scheduler_top_tb;
    import ppr_pkg::*;

    localparam int NJOBS       = MAX_JOBS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 209;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [APB_AW-1:0] TQ_ADDR = APB_AW'(4 * int'(REG_TQ));

    typedef enum logic [1:0] {
        JOB_NEW,
        JOB_READY,
        JOB_RUN,
        JOB_EXIT
    } job_state_e;

    typedef struct {
        logic              op;
        logic [ID_W-1:0]   job_id;
        logic [HALF_W-1:0] arrival;
        logic [HALF_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } sched_req_t;

    typedef struct {
        logic              ran_valid;
        logic [ID_W-1:0]   ran_id;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
        logic              table_full;
    } sched_res_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_op = OP_ADMIT;
    logic [ID_W-1:0]   i_job_id = '0;
    logic [HALF_W-1:0] i_arrival = '0;
    logic [HALF_W-1:0] i_burst = '0;
    logic [PRIO_W-1:0] i_prio = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_ran_valid;
    logic [ID_W-1:0]   o_ran_id;
    logic              o_finished;
    logic [TIME_W-1:0] o_completion_time;
    logic [TIME_W-1:0] o_turnaround;
    logic [TIME_W-1:0] o_waiting;
    logic              o_all_done;
    logic              o_table_full;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    preemptive_priority_rr_scheduler_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_job_id          (i_job_id),
        .i_arrival         (i_arrival),
        .i_burst           (i_burst),
        .i_prio            (i_prio),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_ran_valid       (o_ran_valid),
        .o_ran_id          (o_ran_id),
        .o_finished        (o_finished),
        .o_completion_time (o_completion_time),
        .o_turnaround      (o_turnaround),
        .o_waiting         (o_waiting),
        .o_all_done        (o_all_done),
        .o_table_full      (o_table_full),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #10 i_clk = ~i_clk;

    // scheduler shadow state
    logic [ID_W-1:0]   jt_id    [NJOBS];
    logic [HALF_W-1:0] jt_arr   [NJOBS];
    logic [HALF_W-1:0] jt_burst [NJOBS];
    logic [HALF_W-1:0] jt_rem   [NJOBS];
    logic [PRIO_W-1:0] jt_prio  [NJOBS];
    job_state_e        jt_state [NJOBS];
    int unsigned       rq_slot  [NJOBS];
    int unsigned       rq_len = 0;
    int unsigned       run_slot = 0;
    logic              run_busy = 1'b0;
    logic [HALF_W-1:0] run_slice = '0;
    logic [TIME_W-1:0] sim_now = '0;
    int unsigned       n_loaded = 0;
    int unsigned       n_exited = 0;
    logic [HALF_W-1:0] cur_tq = TQ_RESET;

    sched_req_t pending_reqs[$];
    sched_res_t expected_res[$];
    sched_req_t cur_req;

    int errors = 0;
    int n_ticks = 0;
    int n_admits = 0;
    int n_rejects = 0;
    int n_ran = 0;
    int n_checked = 0;
    int n_tq_writes = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int idle_cycles = 0;
    int gen_now = 0;
    int gen_loaded = 0;
    logic no_gaps = 1'b0;

    function automatic void rq_insert(int unsigned slot);
        int unsigned pos;
        pos = 0;
        if (rq_len >= NJOBS) return;
        while (pos < rq_len && jt_prio[rq_slot[pos]] <= jt_prio[slot]) pos++;
        for (int unsigned k = rq_len; k > pos; k--) rq_slot[k] = rq_slot[k - 1];
        rq_slot[pos] = slot;
        rq_len++;
    endfunction

    function automatic int unsigned rq_pop();
        int unsigned head;
        head = rq_slot[0];
        for (int unsigned k = 1; k < rq_len; k++) rq_slot[k - 1] = rq_slot[k];
        rq_len--;
        return head;
    endfunction

    function automatic sched_res_t sched_step(sched_req_t r);
        sched_res_t  o;
        int unsigned s;
        logic [16:0] q;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
        o = '{default: '0};
        if (r.op == OP_ADMIT) begin
            n_admits++;
            if (n_loaded >= NJOBS) begin
                o.table_full = 1'b1;
                n_rejects++;
            end else begin
                s = n_loaded;
                jt_id[s]    = r.job_id;
                jt_arr[s]   = r.arrival;
                jt_burst[s] = r.burst;
                jt_rem[s]   = r.burst;
                jt_prio[s]  = r.prio;
                jt_state[s] = JOB_NEW;
                n_loaded++;
            end
        end else begin
            n_ticks++;
            for (int unsigned i = 0; i < n_loaded; i++) begin
                if (jt_state[i] == JOB_NEW && sim_now >= TIME_W'(jt_arr[i])) begin
                    rq_insert(i);
                    jt_state[i] = JOB_READY;
                end
            end
            if (!run_busy && rq_len > 0) begin
                run_slot = rq_pop();
                run_busy = 1'b1;
                run_slice = '0;
                jt_state[run_slot] = JOB_RUN;
            end
            if (sim_now != '1) sim_now++;
            if (run_busy) begin
                s = run_slot;
                q = (cur_tq == 0) ? 17'd1 : {1'b0, cur_tq};
                if (jt_rem[s] > 0) jt_rem[s]--;
                if (run_slice < 16'hFFFF) run_slice++;
                o.ran_valid = 1'b1;
                o.ran_id = jt_id[s];
                n_ran++;
                if (jt_rem[s] == 0) begin
                    tat = (sim_now >= TIME_W'(jt_arr[s])) ? sim_now - TIME_W'(jt_arr[s]) : '0;
                    wt = (tat >= TIME_W'(jt_burst[s])) ? tat - TIME_W'(jt_burst[s]) : '0;
                    jt_state[s] = JOB_EXIT;
                    n_exited++;
                    run_busy = 1'b0;
                    o.finished = 1'b1;
                    o.completion_time = sim_now;
                    o.turnaround = tat;
                    o.waiting = wt;
                end else if ({1'b0, run_slice} >= q ||
                             (rq_len > 0 && jt_prio[s] > jt_prio[rq_slot[0]])) begin
                    jt_state[s] = JOB_READY;
                    run_busy = 1'b0;
                    rq_insert(s);
                end
            end
        end
        o.all_done = (n_exited == n_loaded);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_res.push_back(sched_step(cur_req));
                if (!no_gaps && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 10);
            end
            if (!i_valid || o_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_valid   <= 1'b1;
                    i_op      <= cur_req.op;
                    i_job_id  <= cur_req.job_id;
                    i_arrival <= cur_req.arrival;
                    i_burst   <= cur_req.burst;
                    i_prio    <= cur_req.prio;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        sched_res_t e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual id %0h",
                             $time, o_ran_id);
                    errors++;
                end else begin
                    e = expected_res.pop_front();
                    n_checked++;
                    check_field("ran_valid", e.ran_valid, o_ran_valid);
                    check_field("ran_id", e.ran_id, o_ran_id);
                    check_field("finished", e.finished, o_finished);
                    check_field("completion_time", e.completion_time, o_completion_time);
                    check_field("turnaround", e.turnaround, o_turnaround);
                    check_field("waiting", e.waiting, o_waiting);
                    check_field("all_done", e.all_done, o_all_done);
                    check_field("table_full", e.table_full, o_table_full);
                end
                if (!no_gaps && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 10);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 15) == 0) sink_gap = $urandom_range(1, 10);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL preemptive_priority_rr_scheduler_top");
                $finish;
            end
        end
    end

    task automatic push_admit(input logic [ID_W-1:0] id, input logic [HALF_W-1:0] arr,
                              input logic [HALF_W-1:0] bst, input logic [PRIO_W-1:0] pri);
        sched_req_t r;
        r.op = OP_ADMIT;
        r.job_id = id;
        r.arrival = arr;
        r.burst = bst;
        r.prio = pri;
        pending_reqs.push_back(r);
        if (gen_loaded < NJOBS) gen_loaded++;
    endtask

    task automatic push_tick(input int n);
        sched_req_t r;
        for (int i = 0; i < n; i++) begin
            r.op = OP_TICK;
            r.job_id = ID_W'($urandom);
            r.arrival = HALF_W'($urandom);
            r.burst = HALF_W'($urandom);
            r.prio = PRIO_W'($urandom);
            pending_reqs.push_back(r);
            gen_now++;
        end
    endtask

    task automatic push_random_item();
        logic [HALF_W-1:0] arr;
        logic [HALF_W-1:0] bst;
        logic [PRIO_W-1:0] pri;
        if ((gen_loaded < NJOBS) ? ($urandom_range(0, 24) == 0) : ($urandom_range(0, 19) == 0))
        begin
            if (gen_loaded == NJOBS - 1) begin
                // last slot: a job that never arrives
                push_admit(ID_W'($urandom), 16'hFFFF, 16'hFFFF, PRIO_W'($urandom));
            end else begin
                arr = ($urandom_range(0, 7) == 0) ? HALF_W'($urandom)
                                                  : HALF_W'(gen_now + $urandom_range(0, 60));
                pri = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 255))
                                                  : PRIO_W'($urandom_range(10, 12));
                if ($urandom_range(0, 9) == 0) begin
                    bst = HALF_W'($urandom_range(1, 65535));
                    pri = 8'hFF;
                end else begin
                    bst = HALF_W'($urandom_range(1, 40));
                end
                push_admit(ID_W'($urandom), arr, bst, pri);
            end
        end else begin
            push_tick(1);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (NJOBS + 10) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [HALF_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TQ_ADDR;
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cur_tq = val;
        n_tq_writes++;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[HALF_W-1:0] !== val) begin
            $display("%0t: time_quantum readback mismatch, expected %0h, actual %0h",
                     $time, val, prdata[HALF_W-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [HALF_W-1:0] tq_set [3];
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset quantum: idle tick on an empty table, zero burst, extreme ids
        push_tick(1);
        push_admit(16'hFFFF, 16'h0000, 16'h0000, 8'h00);
        push_admit(16'h0000, 16'h0000, 16'h0001, 8'hFF);
        push_tick(3);
        wait_drained();

        // zero quantum behaves as one: equal-priority round robin, then preemption
        write_quantum(16'h0000);
        push_admit(16'hA5A5, HALF_W'(gen_now), 16'd3, 8'd5);
        push_admit(16'h5A5A, HALF_W'(gen_now), 16'd3, 8'd5);
        push_admit(16'h0F0F, HALF_W'(gen_now + 3), 16'd2, 8'd1);
        push_tick(8);
        wait_drained();

        // max quantum: FIFO among equals, urgent arrival takes the CPU
        write_quantum(16'hFFFF);
        push_admit(16'h1111, HALF_W'(gen_now), 16'd4, 8'd200);
        push_admit(16'h2222, HALF_W'(gen_now + 1), 16'd2, 8'd200);
        push_admit(16'h3333, HALF_W'(gen_now + 2), 16'd3, 8'd100);
        push_tick(6);
        wait_drained();

        tq_set[0] = 16'd3;
        tq_set[1] = 16'd1;
        tq_set[2] = HALF_W'($urandom_range(2, 8));
        for (int p = 0; p < 3; p++) begin
            write_quantum(tq_set[p]);
            if (p == 2) no_gaps = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) push_random_item();
            wait_drained();
        end

        $display("Run covered %0d requests: %0d ticks, %0d admits (%0d rejected as table full)",
                 n_ticks + n_admits, n_ticks, n_admits, n_rejects);
        $display("%0d results checked, %0d ticks ran a job, %0d jobs completed, %0d quantum writes",
                 n_checked, n_ran, n_exited, n_tq_writes);
        if (errors == 0) begin
            $display("PASS preemptive_priority_rr_scheduler_top");
        end else begin
            $display("FAIL preemptive_priority_rr_scheduler_top");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ppr_pkg.sv
hw/rtl/ppr_cell.sv
hw/rtl/ppr_queue.sv
hw/rtl/ppr_job_mem.sv
hw/rtl/preemptive_priority_rr_scheduler_top.sv
hw/rtl/ppr_checker.sv
tb/preemptive_priority_rr_scheduler_top_tb.sv
